// File: src/hscl_pkg.sv
`default_nettype none
package hscl_pkg;

  localparam int WORD_W  = 16;
  localparam int COUNT_W = WORD_W + 1;
  localparam int MILLI_W = 14;
  localparam int FIELD_W = 32;
  localparam int N_AXES  = 3;
  localparam int N_SENS  = 64;

  localparam int MILLI_SCALE = 1000;
  localparam int MILLI_HALF  = 500;

  localparam int STATUS_ERR_BIT = 4;

  localparam logic [1:0] RES_17 = 2'd2;
  localparam logic [1:0] RES_18 = 2'd3;

  localparam logic [COUNT_W-1:0] RES17_OFFSET = 17'h08000;
  localparam logic [COUNT_W-1:0] RES18_OFFSET = 17'h04000;

  localparam logic [2:0] REG_GAIN  = 3'd0;
  localparam logic [2:0] REG_X_RES = 3'd1;
  localparam logic [2:0] REG_Y_RES = 3'd2;
  localparam logic [2:0] REG_Z_RES = 3'd3;
  localparam logic [2:0] REG_TCOMP = 3'd4;

  localparam logic [2:0] GAIN_RST  = 3'd7;
  localparam logic [1:0] X_RES_RST = 2'd1;
  localparam logic [1:0] Y_RES_RST = 2'd1;
  localparam logic [1:0] Z_RES_RST = 2'd0;

  typedef struct packed {
    logic [2:0] gain;
    logic [1:0] x_res;
    logic [1:0] y_res;
    logic [1:0] z_res;
    logic       temp_comp;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic fresh;
  } stage_ctl_t;

  typedef logic [MILLI_W-1:0] milli_arr_t [N_SENS];

  // sensitivity in 0.001 uT/LSB, index {gain, res, is_z}
  localparam milli_arr_t SENS_MILLI = '{
    14'd751,  14'd1210, 14'd1502, 14'd2420, 14'd3004, 14'd4840, 14'd6009, 14'd9680,
    14'd601,  14'd968,  14'd1202, 14'd1936, 14'd2403, 14'd3872, 14'd4840, 14'd7744,
    14'd451,  14'd726,  14'd901,  14'd1452, 14'd1803, 14'd2904, 14'd3605, 14'd5808,
    14'd376,  14'd605,  14'd751,  14'd1210, 14'd1502, 14'd2420, 14'd3004, 14'd4840,
    14'd300,  14'd484,  14'd601,  14'd968,  14'd1202, 14'd1936, 14'd2403, 14'd3872,
    14'd250,  14'd403,  14'd501,  14'd807,  14'd1001, 14'd1613, 14'd2003, 14'd3227,
    14'd200,  14'd323,  14'd401,  14'd645,  14'd801,  14'd1291, 14'd1602, 14'd2581,
    14'd150,  14'd242,  14'd300,  14'd484,  14'd601,  14'd968,  14'd1202, 14'd1936
  };

endpackage
`default_nettype wire

// File: src/hscl_cfg.sv
`default_nettype none
module hscl_cfg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output hscl_pkg::cfg_t           cfg
);

  hscl_pkg::cfg_t cfg_r;
  hscl_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        hscl_pkg::REG_GAIN:  cfg_nxt.gain      = pwdata[2:0];
        hscl_pkg::REG_X_RES: cfg_nxt.x_res     = pwdata[1:0];
        hscl_pkg::REG_Y_RES: cfg_nxt.y_res     = pwdata[1:0];
        hscl_pkg::REG_Z_RES: cfg_nxt.z_res     = pwdata[1:0];
        hscl_pkg::REG_TCOMP: cfg_nxt.temp_comp = pwdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain      <= hscl_pkg::GAIN_RST;
      cfg_r.x_res     <= hscl_pkg::X_RES_RST;
      cfg_r.y_res     <= hscl_pkg::Y_RES_RST;
      cfg_r.z_res     <= hscl_pkg::Z_RES_RST;
      cfg_r.temp_comp <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      hscl_pkg::REG_GAIN:  prdata = {29'd0, cfg_r.gain};
      hscl_pkg::REG_X_RES: prdata = {30'd0, cfg_r.x_res};
      hscl_pkg::REG_Y_RES: prdata = {30'd0, cfg_r.y_res};
      hscl_pkg::REG_Z_RES: prdata = {30'd0, cfg_r.z_res};
      hscl_pkg::REG_TCOMP: prdata = {31'd0, cfg_r.temp_comp};
      default:             prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/hscl_lane.sv
`default_nettype none
module hscl_lane #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                                          clk,
  input  wire logic                                          en,
  input  wire logic        [hscl_pkg::WORD_W-1:0]            word,
  input  wire logic        [1:0]                             res,
  input  wire logic        [2:0]                             gain,
  input  wire logic                                          is_z,
  input  wire logic                                          temp_comp,
  output logic signed      [hscl_pkg::WORD_W-1:0]            raw,
  output logic signed      [hscl_pkg::COUNT_W+hscl_pkg::MILLI_W+FRAC_BITS:0] prod
);

  localparam int SENS_W = hscl_pkg::MILLI_W + FRAC_BITS;
  localparam int ACC_W  = SENS_W + 10;
  localparam int PROD_W = hscl_pkg::COUNT_W + SENS_W + 1;

  typedef logic [SENS_W-1:0] sens_arr_t [hscl_pkg::N_SENS];

  function automatic sens_arr_t build_sens();
    sens_arr_t        t;
    logic [ACC_W-1:0] acc;
    for (int i = 0; i < hscl_pkg::N_SENS; i++) begin
      acc  = (ACC_W'(hscl_pkg::SENS_MILLI[i]) << FRAC_BITS) + ACC_W'(hscl_pkg::MILLI_HALF);
      t[i] = SENS_W'(acc / hscl_pkg::MILLI_SCALE);
    end
    return t;
  endfunction

  localparam sens_arr_t SENS_FIX = build_sens();

  logic        [hscl_pkg::COUNT_W-1:0] ext_word;
  logic        [hscl_pkg::COUNT_W-1:0] count;
  logic        [5:0]                   sens_idx;
  logic signed [hscl_pkg::COUNT_W-1:0] count_r;
  logic        [SENS_W-1:0]            sens_r;
  logic        [hscl_pkg::WORD_W-1:0]  raw1_r;
  logic signed [PROD_W-1:0]            prod_r;
  logic        [hscl_pkg::WORD_W-1:0]  raw2_r;

  assign ext_word = {1'b0, word};
  assign sens_idx = {gain, res, is_z};

  always_comb begin
    if (!temp_comp && res == hscl_pkg::RES_17) begin
      count = ext_word - hscl_pkg::RES17_OFFSET;
    end else if (!temp_comp && res == hscl_pkg::RES_18) begin
      count = ext_word - hscl_pkg::RES18_OFFSET;
    end else begin
      count = {word[hscl_pkg::WORD_W-1], word};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      count_r <= count;
      sens_r  <= SENS_FIX[sens_idx];
      raw1_r  <= word;
      prod_r  <= PROD_W'(count_r) * PROD_W'($signed({1'b0, sens_r}));
      raw2_r  <= raw1_r;
    end
  end

  assign prod = prod_r;
  assign raw  = raw2_r;

endmodule
`default_nettype wire

// File: src/hscl_merge.sv
`default_nettype none
module hscl_merge #(
  parameter int PROD_W = 44
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    en,
  input  wire hscl_pkg::stage_ctl_t                    ctl,
  input  wire logic signed [PROD_W-1:0]                prod [hscl_pkg::N_AXES],
  input  wire logic signed [hscl_pkg::WORD_W-1:0]      raw  [hscl_pkg::N_AXES],
  output logic             [hscl_pkg::FIELD_W-1:0]     field_o [hscl_pkg::N_AXES],
  output logic             [hscl_pkg::WORD_W-1:0]      raw_o   [hscl_pkg::N_AXES],
  output logic                                         out_vld,
  output logic                                         out_fresh
);

  localparam int FW = hscl_pkg::FIELD_W;
  localparam logic [FW-1:0] SAT_MAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic [FW-1:0] SAT_MIN = {1'b1, {(FW-1){1'b0}}};

  logic [FW-1:0]               sat   [hscl_pkg::N_AXES];
  logic [FW-1:0]               held_field_r [hscl_pkg::N_AXES];
  logic [hscl_pkg::WORD_W-1:0] held_raw_r   [hscl_pkg::N_AXES];
  logic                        vld_r;
  logic                        fresh_r;
  logic                        load;

  always_comb begin
    for (int a = 0; a < hscl_pkg::N_AXES; a++) begin
      if (prod[a][PROD_W-1:FW-1] == '0 || prod[a][PROD_W-1:FW-1] == '1) begin
        sat[a] = prod[a][FW-1:0];
      end else if (prod[a][PROD_W-1]) begin
        sat[a] = SAT_MIN;
      end else begin
        sat[a] = SAT_MAX;
      end
    end
  end

  assign load = en & ctl.vld & ctl.fresh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      fresh_r <= 1'b0;
      for (int a = 0; a < hscl_pkg::N_AXES; a++) begin
        held_field_r[a] <= '0;
        held_raw_r[a]   <= '0;
      end
    end else begin
      if (en) begin
        vld_r   <= ctl.vld;
        fresh_r <= ctl.fresh;
      end
      if (load) begin
        for (int a = 0; a < hscl_pkg::N_AXES; a++) begin
          held_field_r[a] <= sat[a];
          held_raw_r[a]   <= raw[a];
        end
      end
    end
  end

  assign field_o   = held_field_r;
  assign raw_o     = held_raw_r;
  assign out_vld   = vld_r;
  assign out_fresh = fresh_r;

endmodule
`default_nettype wire

// File: src/hall_sensor_sample_scaler_core.sv
`default_nettype none
// Hall magnetometer frame scaler.
// Input stream: in_tdata carries the x, y and z axis words, in_tuser the sensor
// status byte. A frame with status bit 4 set is an error frame: the last good
// fields and raw words are sent again with fresh (out_tuser) low.
// Output stream: out_tdata carries field x/y/z (signed, FIELD_FRAC_BITS
// fractional bits, microtesla) and the raw words; out_tuser is fresh.
// Three axis lanes each form the count, look up the sensitivity and multiply;
// a merge stage saturates, holds the last good result and drives the output.
// Each frame passes the two lane stages and then the output register. Throughput:
// one frame per cycle while the output is not stalled.
// Downstream stall: the whole pipe freezes and in_tready drops while
// out_tvalid is high and out_tready is low.
// Reset: configuration returns to gain 7, x/y resolution code 1, z code 0,
// temperature compensation off; held results clear to zero; pipe empties. Configuration
// must be written through the APB port while no frame is in flight (block does not check).
module hall_sensor_sample_scaler_core #(
  parameter int FIELD_FRAC_BITS = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [47:0]   in_tdata,   // word_x, word_y, word_z
  input  wire logic [7:0]    in_tuser,   // status_byte
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [143:0]       out_tdata,  // field_x, field_y, field_z, raw_x, raw_y, raw_z
  output logic [0:0]         out_tuser,  // fresh
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int WW     = hscl_pkg::WORD_W;
  localparam int NA     = hscl_pkg::N_AXES;
  localparam int PROD_W = hscl_pkg::COUNT_W + hscl_pkg::MILLI_W + FIELD_FRAC_BITS + 1;

  hscl_pkg::cfg_t       cfg;
  hscl_pkg::stage_ctl_t s1_r;
  hscl_pkg::stage_ctl_t s2_r;
  logic                 en;
  logic                 in_xfer;
  logic [1:0]           res_sel [NA];
  logic signed [PROD_W-1:0]    prod [NA];
  logic signed [WW-1:0]        raw  [NA];
  logic [hscl_pkg::FIELD_W-1:0] field_o [NA];
  logic [WW-1:0]               raw_o   [NA];
  logic                        out_fresh;

  hscl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign in_xfer   = in_tvalid & in_tready;

  assign res_sel[0] = cfg.x_res;
  assign res_sel[1] = cfg.y_res;
  assign res_sel[2] = cfg.z_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (en) begin
      s1_r.vld   <= in_xfer;
      s1_r.fresh <= !in_tuser[hscl_pkg::STATUS_ERR_BIT];
      s2_r       <= s1_r;
    end
  end

  for (genvar g = 0; g < NA; g++) begin : g_lane
    hscl_lane #(
      .FRAC_BITS (FIELD_FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .en        (en),
      .word      (in_tdata[g*WW +: WW]),
      .res       (res_sel[g]),
      .gain      (cfg.gain),
      .is_z      (g == NA - 1),
      .temp_comp (cfg.temp_comp),
      .raw       (raw[g]),
      .prod      (prod[g])
    );
  end

  hscl_merge #(
    .PROD_W (PROD_W)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl       (s2_r),
    .prod      (prod),
    .raw       (raw),
    .field_o   (field_o),
    .raw_o     (raw_o),
    .out_vld   (out_tvalid),
    .out_fresh (out_fresh)
  );

  assign out_tdata = {raw_o[2], raw_o[1], raw_o[0], field_o[2], field_o[1], field_o[0]};
  assign out_tuser = out_fresh;

endmodule
`default_nettype wire

// File: src/hscl_chk.sv
`default_nettype none
module hscl_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [7:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [143:0] out_tdata,
  input wire logic [0:0]   out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  a_stall_only_downstream: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  a_latency_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 out_tready ##1 out_tready |=>
      out_tvalid && (out_tuser[0] == !$past(in_tuser[hscl_pkg::STATUS_ERR_BIT], 3)))
    else $error("frame missing or fresh flag wrong after three cycles");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind hall_sensor_sample_scaler_core hscl_chk u_hscl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// File: verif/hall_sensor_sample_scaler_core_tb.sv
`timescale 1ns / 100ps

module hall_sensor_sample_scaler_core_tb;

  localparam int FIELD_FRAC = 12;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 6;
  localparam int N_ROWS = 16;
  localparam int N_PHASES = 8;
  localparam int FRAMES_PER_PHASE = 100;

  // sensitivity in 0.001 uT/LSB, index {gain, res, is_z}
  localparam int unsigned UT_PER_LSB_MILLI [64] = '{
    751,  1210, 1502, 2420, 3004, 4840, 6009, 9680,
    601,  968,  1202, 1936, 2403, 3872, 4840, 7744,
    451,  726,  901,  1452, 1803, 2904, 3605, 5808,
    376,  605,  751,  1210, 1502, 2420, 3004, 4840,
    300,  484,  601,  968,  1202, 1936, 2403, 3872,
    250,  403,  501,  807,  1001, 1613, 2003, 3227,
    200,  323,  401,  645,  801,  1291, 1602, 2581,
    150,  242,  300,  484,  601,  968,  1202, 1936
  };

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
    logic               fresh;
  } scaled_frame_t;

  typedef struct packed {
    logic            is_cfg;
    hscl_pkg::cfg_t  cfg;
    logic [7:0]      status;
    logic [15:0]     wx;
    logic [15:0]     wy;
    logic [15:0]     wz;
    logic            known;
    scaled_frame_t   want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;   // word_x, word_y, word_z
  logic [7:0]   in_tuser = '0;   // status_byte
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;       // field_x, field_y, field_z, raw_x, raw_y, raw_z
  logic [0:0]   out_tuser;       // fresh
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  hall_sensor_sample_scaler_core #(
    .FIELD_FRAC_BITS(FIELD_FRAC)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  hscl_pkg::cfg_t cur_cfg;
  scaled_frame_t  held_frame;
  scaled_frame_t  pending_frames [$];
  dir_row_t       dir_rows [N_ROWS];
  logic           no_idle = 1'b0;
  int             n_errors = 0;
  int             n_sent = 0;
  int             n_err_frames = 0;
  int             n_checked = 0;
  int             n_settings = 0;
  int             quiet_cycles = 0;

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  function automatic logic signed [31:0] axis_field(input logic [15:0] w,
                                                     input logic [1:0] res,
                                                     input logic is_z);
    longint cnt;
    longint sens;
    longint prod;
    if (!cur_cfg.temp_comp && res == hscl_pkg::RES_17) begin
      cnt = longint'(w) - longint'(hscl_pkg::RES17_OFFSET);
    end else if (!cur_cfg.temp_comp && res == hscl_pkg::RES_18) begin
      cnt = longint'(w) - longint'(hscl_pkg::RES18_OFFSET);
    end else begin
      cnt = longint'($signed(w));
    end
    sens = ((longint'(UT_PER_LSB_MILLI[{cur_cfg.gain, res, is_z}]) << FIELD_FRAC)
            + hscl_pkg::MILLI_HALF) / hscl_pkg::MILLI_SCALE;
    prod = cnt * sens;
    if (prod > 64'sd2147483647) prod = 64'sd2147483647;
    if (prod < -64'sd2147483648) prod = -64'sd2147483648;
    return prod[31:0];
  endfunction

  // updates the held result on a good frame
  function automatic scaled_frame_t scale_frame(input logic [7:0] st,
                                                input logic [15:0] wx, wy, wz);
    scaled_frame_t r;
    if (!st[hscl_pkg::STATUS_ERR_BIT]) begin
      held_frame.fx = axis_field(wx, cur_cfg.x_res, 1'b0);
      held_frame.fy = axis_field(wy, cur_cfg.y_res, 1'b0);
      held_frame.fz = axis_field(wz, cur_cfg.z_res, 1'b1);
      held_frame.rx = wx;
      held_frame.ry = wy;
      held_frame.rz = wz;
    end
    r = held_frame;
    r.fresh = !st[hscl_pkg::STATUS_ERR_BIT];
    return r;
  endfunction

  task automatic send_frame(input logic [7:0] st, input logic [15:0] wx, wy, wz,
                            input logic known, input scaled_frame_t want);
    scaled_frame_t pred;
    if (!no_idle && $urandom_range(0, 99) < 22) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 22);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= st;
    in_tdata  <= {wz, wy, wx};
    do @(posedge clk); while (!in_tready);
    pred = scale_frame(st, wx, wy, wz);
    pending_frames.push_back(known ? want : pred);
    n_sent++;
    if (st[hscl_pkg::STATUS_ERR_BIT]) n_err_frames++;
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic [2:0] idx, input logic wr, input logic [31:0] data,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
  endtask

  task automatic set_config(input hscl_pkg::cfg_t c);
    logic [31:0] vals [5];
    logic [31:0] rd;
    wait_results_done();
    vals[hscl_pkg::REG_GAIN]  = 32'(c.gain);
    vals[hscl_pkg::REG_X_RES] = 32'(c.x_res);
    vals[hscl_pkg::REG_Y_RES] = 32'(c.y_res);
    vals[hscl_pkg::REG_Z_RES] = 32'(c.z_res);
    vals[hscl_pkg::REG_TCOMP] = 32'(c.temp_comp);
    for (int r = hscl_pkg::REG_GAIN; r <= hscl_pkg::REG_TCOMP; r++) begin
      apb_access(3'(r), 1'b1, vals[r], rd);
    end
    for (int r = hscl_pkg::REG_GAIN; r <= hscl_pkg::REG_TCOMP; r++) begin
      apb_access(3'(r), 1'b0, '0, rd);
      check_field($sformatf("register %0d readback", r), vals[r], rd);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_cfg = c;
    n_settings++;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 19))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'h4000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  always @(posedge clk) begin
    out_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk) begin : result_check
    scaled_frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_frames.size() == 0) begin
        $error("result transfer with nothing expected");
        n_errors++;
      end else begin
        want = pending_frames.pop_front();
        check_field("field_x", want.fx, $signed(out_tdata[31:0]));
        check_field("field_y", want.fy, $signed(out_tdata[63:32]));
        check_field("field_z", want.fz, $signed(out_tdata[95:64]));
        check_field("raw_x", want.rx, $signed(out_tdata[111:96]));
        check_field("raw_y", want.ry, $signed(out_tdata[127:112]));
        check_field("raw_z", want.rz, $signed(out_tdata[143:128]));
        check_field("fresh", want.fresh, out_tuser[0]);
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    hscl_pkg::cfg_t c;
    logic [7:0]     st;
    dir_row_t       row;
    cur_cfg    = '{hscl_pkg::GAIN_RST, hscl_pkg::X_RES_RST, hscl_pkg::Y_RES_RST,
                   hscl_pkg::Z_RES_RST, 1'b0};
    held_frame = '0;
    dir_rows = '{
      '{1'b0, hscl_pkg::cfg_t'('0), 8'h10, 16'h1234, 16'hABCD, 16'h8001, 1'b1,
        scaled_frame_t'('0)},
      '{1'b0, hscl_pkg::cfg_t'('0), 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1,
        '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}},
      '{1'b0, hscl_pkg::cfg_t'('0), 8'hEF, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b0,
        scaled_frame_t'('0)},
      '{1'b0, hscl_pkg::cfg_t'('0), 8'hFF, 16'h5555, 16'hAAAA, 16'h0F0F, 1'b0,
        scaled_frame_t'('0)},
      '{1'b1, '{3'd0, 2'd2, 2'd3, 2'd3, 1'b0}, 8'h00, 16'h0, 16'h0, 16'h0, 1'b0,
        scaled_frame_t'('0)},
      '{1'b0, hscl_pkg::cfg_t'('0), 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0,
        scaled_frame_t'('0)},
      '{1'b0, hscl_pkg::cfg_t'('0), 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0,
        scaled_frame_t'('0)},
      // offsets cancel exactly: zero field, raw words pass through
      '{1'b0, hscl_pkg::cfg_t'('0), 8'h00, 16'h8000, 16'h4000, 16'h4000, 1'b1,
        '{32'sd0, 32'sd0, 32'sd0, 16'h8000, 16'h4000, 16'h4000, 1'b1}},
      '{1'b0, hscl_pkg::cfg_t'('0), 8'h10, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0,
        scaled_frame_t'('0)},
      '{1'b1, '{3'd7, 2'd3, 2'd2, 2'd2, 1'b1}, 8'h00, 16'h0, 16'h0, 16'h0, 1'b0,
        scaled_frame_t'('0)},
      '{1'b0, hscl_pkg::cfg_t'('0), 8'h00, 16'h8000, 16'hFFFF, 16'h7FFF, 1'b0,
        scaled_frame_t'('0)},
      '{1'b0, hscl_pkg::cfg_t'('0), 8'h6E, 16'hAAAA, 16'h5555, 16'hC3C3, 1'b0,
        scaled_frame_t'('0)},
      '{1'b1, '{3'd3, 2'd0, 2'd1, 2'd1, 1'b0}, 8'h00, 16'h0, 16'h0, 16'h0, 1'b0,
        scaled_frame_t'('0)},
      '{1'b0, hscl_pkg::cfg_t'('0), 8'hEF, 16'h0001, 16'hFFFE, 16'h1234, 1'b0,
        scaled_frame_t'('0)},
      '{1'b0, hscl_pkg::cfg_t'('0), 8'h10, 16'h0000, 16'h0000, 16'h0000, 1'b0,
        scaled_frame_t'('0)},
      '{1'b0, hscl_pkg::cfg_t'('0), 8'h00, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0,
        scaled_frame_t'('0)}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) set_config(row.cfg);
      else send_frame(row.status, row.wx, row.wy, row.wz, row.known, row.want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: c = '{3'd7, 2'd3, 2'd3, 2'd3, 1'b1};
        1: c = '{3'd0, 2'd0, 2'd0, 2'd0, 1'b0};
        2: c = '{3'd7, 2'd2, 2'd3, 2'd2, 1'b0};
        3: c = '{3'd0, 2'd3, 2'd2, 2'd3, 1'b0};
        default: c = '{3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                       2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1))};
      endcase
      set_config(c);
      no_idle = (ph == 4);
      for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
        st = 8'($urandom_range(0, 255));
        st[hscl_pkg::STATUS_ERR_BIT] = ($urandom_range(0, 3) == 0);
        send_frame(st, pick_word(), pick_word(), pick_word(), 1'b0, scaled_frame_t'('0));
        if (ph == 2 && k == FRAMES_PER_PHASE / 2) wait_results_done();
      end
      no_idle = 1'b0;
    end

    wait_results_done();
    $display("Sent %0d frames (%0d error frames) over %0d register settings;",
             n_sent, n_err_frames, n_settings);
    $display("checked %0d result transfers, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
